>>> rtl/spf_pkg.sv
// spf_pkg: constants, payload types and frame codes for the SPI packet framer.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package spf_pkg;

    // Frame constants
    localparam logic [6:0] MAX_LEN   = 7'd64;
    localparam logic [7:0] CMD_BYTE  = 8'hF0;
    localparam logic [7:0] XOR_TAIL  = 8'h5F;
    localparam logic [7:0] TYPE_FLAG = 8'h80;
    localparam logic [7:0] HDR_SLOTS = 8'd2;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Results one item can cause, and a count able to hold that number
    localparam int RES_MAX = 4;
    localparam int CNT_W   = $clog2(RES_MAX + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       check_ok;
        logic       length_error;
    } result_t;

    typedef result_t [RES_MAX-1:0] res_vec_t;

    // Transaction state carried from item to item
    typedef struct packed {
        logic [7:0] slot_index;
        logic [7:0] running_xor;
        logic [6:0] held_length;
        logic       held_operation;
        logic       busy;
    } state_t;

    // Results of one item, handed to the output buffer
    typedef struct packed {
        res_vec_t         res;
        logic [CNT_W-1:0] cnt;
    } bundle_t;

endpackage

>>> rtl/spf_req_if.sv
// spf_req_if: input channel of the framer, valid/ready plus one item.
// Depends on spf_pkg for nothing but kept in the same house style.
`timescale 1ns / 1ps

interface spf_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [6:0] length;
    logic [7:0] data;
    logic       first;

    modport source (output valid, output operation, output length, output data,
                    output first, input ready);
    modport sink   (input valid, input operation, input length, input data,
                    input first, output ready);
endinterface

>>> rtl/spf_rsp_if.sv
// spf_rsp_if: result channel of the framer, valid/ready plus one result item.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface spf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       check_ok;
    logic       length_error;

    modport source (output valid, output out_byte, output last, output check_ok,
                    output length_error, input ready);
    modport sink   (input valid, input out_byte, input last, input check_ok,
                    input length_error, output ready);
endinterface

>>> rtl/spf_step.sv
// spf_step: combinational per-item logic; next transaction state and the
// results (up to four) one item causes. Depends on spf_pkg.
`timescale 1ns / 1ps

module spf_step (
    input  spf_pkg::state_t  state,
    input  logic             operation,
    input  logic [6:0]       length,
    input  logic [7:0]       data,
    input  logic             first,
    output spf_pkg::state_t  state_next,
    output spf_pkg::bundle_t bundle
);

    always_comb
    begin
        spf_pkg::state_t          s;
        spf_pkg::res_vec_t        res;
        logic [spf_pkg::CNT_W-1:0] n;
        logic                     done;
        logic [7:0]               type_byte;
        logic [7:0]               slot_inc;

        s         = state;
        res       = '0;
        n         = '0;
        done      = 1'b0;
        type_byte = spf_pkg::TYPE_FLAG | {1'b0, length};
        slot_inc  = state.slot_index + 8'd1;

        // Start of a transaction: header or rejection
        if (first)
        begin
            s.busy = 1'b0;
            s.slot_index = '0;
            if (length == 7'd0 || length > spf_pkg::MAX_LEN)
            begin
                res[0].length_error = 1'b1;
                res[0].last         = 1'b1;
                n    = spf_pkg::CNT_W'(1);
                done = 1'b1;
            end
            else
            begin
                s.held_length    = length;
                s.held_operation = operation;
                s.busy           = 1'b1;
                if (operation == spf_pkg::OP_WRITE)
                begin
                    s.running_xor    = spf_pkg::CMD_BYTE ^ type_byte;
                    res[0].out_byte  = spf_pkg::CMD_BYTE;
                    res[1].out_byte  = type_byte;
                    n = spf_pkg::CNT_W'(2);
                end
                else
                begin
                    s.running_xor = {1'b0, length};
                end
            end
            slot_inc = 8'd1;
        end

        // Body of the open transaction
        if (!done && s.busy)
        begin
            if (s.held_operation == spf_pkg::OP_WRITE)
            begin
                s.running_xor = s.running_xor ^ data;
                res[n[1:0]].out_byte = data;
                n = n + spf_pkg::CNT_W'(1);
                s.slot_index = slot_inc;
                if (slot_inc >= {1'b0, s.held_length})
                begin
                    res[n[1:0]].out_byte = s.running_xor ^ spf_pkg::XOR_TAIL;
                    res[n[1:0]].last     = 1'b1;
                    n = n + spf_pkg::CNT_W'(1);
                    s.busy       = 1'b0;
                    s.slot_index = '0;
                end
            end
            else
            begin
                if (s.slot_index < spf_pkg::HDR_SLOTS)
                begin
                    s.slot_index = s.slot_index + 8'd1;
                end
                else if (s.slot_index < {1'b0, s.held_length} + spf_pkg::HDR_SLOTS)
                begin
                    s.running_xor = s.running_xor ^ data;
                    res[n[1:0]].out_byte = data;
                    n = n + spf_pkg::CNT_W'(1);
                    s.slot_index = s.slot_index + 8'd1;
                end
                else
                begin
                    // Check byte: verdict result closes the transaction
                    res[n[1:0]].last     = 1'b1;
                    res[n[1:0]].check_ok =
                        (data == (s.running_xor ^ spf_pkg::XOR_TAIL));
                    n = n + spf_pkg::CNT_W'(1);
                    s.busy       = 1'b0;
                    s.slot_index = '0;
                end
            end
        end

        state_next = s;
        bundle.res = res;
        bundle.cnt = n;
    end

endmodule

>>> rtl/spf_outbuf.sv
// spf_outbuf: result register holding one item's results, shifted out one per
// cycle on the result channel rsp while rsp.ready is high. Depends on spf_pkg and spf_rsp_if.
`timescale 1ns / 1ps

module spf_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  spf_pkg::bundle_t  bundle,
    output logic              can_load,
    spf_rsp_if.source         rsp
);

    spf_pkg::res_vec_t         res_reg;
    spf_pkg::res_vec_t         res_next;
    logic [spf_pkg::CNT_W-1:0] cnt_reg;
    logic [spf_pkg::CNT_W-1:0] cnt_next;
    logic                      fire;

    assign fire     = rsp.valid && rsp.ready;
    assign can_load = (cnt_reg == '0) ||
                      (cnt_reg == spf_pkg::CNT_W'(1) && rsp.ready);

    // Load a new set or shift the head out
    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            res_next = bundle.res;
            cnt_next = bundle.cnt;
        end
        else if (fire)
        begin
            for (int i = 0; i < spf_pkg::RES_MAX - 1; i++)
            begin
                res_next[i] = res_reg[i+1];
            end
            cnt_next = cnt_reg - spf_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign rsp.valid        = (cnt_reg != '0);
    assign rsp.out_byte     = res_reg[0].out_byte;
    assign rsp.last         = res_reg[0].last;
    assign rsp.check_ok     = res_reg[0].check_ok;
    assign rsp.length_error = res_reg[0].length_error;

endmodule

>>> rtl/spi_packet_framer_xor_check_top.sv
// spi_packet_framer_xor_check_top: frame builder and checker for a byte-wide
// SPI radio link. Depends on spf_pkg, spf_req_if, spf_rsp_if, spf_step,
// spf_outbuf.
//
// Usage:
//   req carries one item per handshake: operation, length, data, first.
//   first = 1 opens a transaction and samples operation and length. A write
//   transaction emits 0xF0, the type byte, the payload and a check byte on
//   rsp; a read transaction takes length+3 frame bytes, passes out the data
//   bytes and ends with a verdict item (last = 1, check_ok). A bad length
//   gives one item with length_error = 1.
// Latency: the first result of an item is on rsp the cycle after it is taken.
// Throughput: an item is taken every cycle while each causes at most one
//   result and rsp.ready is high; an item causing more holds req.ready
//   low while the single result register drains them, one per rsp handshake.
//   Items that cause no result wait like any other while two or more results
//   are still queued.
// Reset: rst_n clears the open transaction and empties the result register.
// Stall: when rsp.ready is low the result register holds and req.ready drops
//   once a second set of results would not fit.
`timescale 1ns / 1ps

module spi_packet_framer_xor_check_top (
    input  logic      clk,
    input  logic      rst_n,
    spf_req_if.sink   req,
    spf_rsp_if.source rsp
);

    spf_pkg::state_t  state_reg;
    spf_pkg::state_t  state_next;
    spf_pkg::state_t  step_state;
    spf_pkg::bundle_t bundle;
    logic             can_load;
    logic             accept;

    assign req.ready = can_load;
    assign accept    = req.valid && req.ready;

    // Per-item logic
    spf_step u_step (
        .state      (state_reg),
        .operation  (req.operation),
        .length     (req.length),
        .data       (req.data),
        .first      (req.first),
        .state_next (step_state),
        .bundle     (bundle)
    );

    // Transaction state
    assign state_next = accept ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result register and output serializer
    spf_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .bundle   (bundle),
        .can_load (can_load),
        .rsp      (rsp)
    );

    // Checks
    a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.busy |-> state_reg.slot_index == 8'd0)
        else $error("slot index nonzero with no open transaction");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.busy |->
            state_reg.slot_index <= {1'b0, state_reg.held_length} + spf_pkg::HDR_SLOTS)
        else $error("slot index ran past the frame end");

    a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.length_error |-> rsp.last && rsp.out_byte == 8'd0)
        else $error("length error item malformed");

    a_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.check_ok |-> rsp.last && !rsp.length_error)
        else $error("check_ok outside the verdict item");

    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rsp.valid |-> rsp.ready)
        else $error("item taken while results would be overwritten");

endmodule
